// File: hdl/mprqs_pkg.sv
package mprqs_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int CountWidth        = 5;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DISP = 2'd1,
        KIND_REM  = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOID  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        POL_RR   = 3'd0,
        POL_SJF  = 3'd1,
        POL_SRTN = 3'd2,
        POL_GUAR = 3'd3,
        POL_PRIO = 3'd4
    } policy_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]         task_id;
        logic [15:0]        target_time;
        logic [15:0]        served_time;
        logic signed [15:0] task_priority;
    } entry_t;

endpackage

// File: hdl/mprqs_if.sv
interface mprqs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         task_id;
    logic [15:0]        target_time;
    logic [15:0]        served_time;
    logic signed [15:0] task_priority;

    modport source (output valid, kind, task_id, target_time, served_time, task_priority,
                    input ready);
    modport sink (input valid, kind, task_id, target_time, served_time, task_priority,
                  output ready);
endinterface

interface mprqs_out_if;
    logic       valid;
    logic       ready;
    logic       grant_valid;
    logic [7:0] grant_id;
    logic [1:0] status;
    logic [4:0] queue_count;

    modport source (output valid, grant_valid, grant_id, status, queue_count, input ready);
    modport sink (input valid, grant_valid, grant_id, status, queue_count, output ready);
endinterface

// File: hdl/multi_policy_ready_queue_scheduler.sv
// Channel    Dir  Payload
// in_ch      in   kind, task_id, target_time, served_time, task_priority
// out_ch     out  grant_valid, grant_id, status, queue_count
// policy     cfg  policy_we / policy_wdata
// One item at a time. Enqueue, an ignored kind or an empty queue pass from
// the accept through the output state back to idle when the result is not
// stalled. Dispatch and remove scan the entry memory, one read per cycle,
// then read the entry after the gap once more and close the gap with one
// read and one write per cycle; the entry memory read is registered. Reset
// clears the count and the policy; the memory is not cleared. A stalled
// result holds in the output register and the next item is taken once it
// leaves.
module multi_policy_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = mprqs_pkg::QueueDepthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       policy_we,
    input  logic [2:0] policy_wdata,
    mprqs_in_if.sink   in_ch,
    mprqs_out_if.source out_ch
);
    import mprqs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [2:0]    policy_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] best_reg, best_next;
    entry_t        best_e_reg, best_e_next;
    logic          found_reg, found_next;
    kind_t         kind_reg;
    logic [7:0]    tid_reg;
    logic          gv_reg, gv_next;
    logic [7:0]    gid_reg, gid_next;
    status_t       st_reg, st_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_pending_reg;

    logic          accept;
    entry_t        in_e;
    logic          cand_wins;
    logic signed [16:0] rem_c, rem_b;
    logic [15:0]   tc, tb;
    logic [31:0]   prod_c, prod_b;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_e        = '{in_ch.task_id, in_ch.target_time, in_ch.served_time,
                           in_ch.task_priority};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Candidate against current best for the policy in force.
    always_comb
    begin
        rem_c  = $signed({1'b0, rd_data_reg.target_time}) -
                 $signed({1'b0, rd_data_reg.served_time});
        rem_b  = $signed({1'b0, best_e_reg.target_time}) -
                 $signed({1'b0, best_e_reg.served_time});
        tc     = (rd_data_reg.target_time == 16'd0) ? 16'd1 : rd_data_reg.target_time;
        tb     = (best_e_reg.target_time == 16'd0) ? 16'd1 : best_e_reg.target_time;
        prod_c = rd_data_reg.served_time * tb;
        prod_b = best_e_reg.served_time * tc;
        unique case (policy_reg)
            POL_SJF:  cand_wins = rd_data_reg.target_time < best_e_reg.target_time;
            POL_SRTN: cand_wins = rem_c < rem_b;
            POL_GUAR: cand_wins = prod_c < prod_b;
            POL_PRIO: cand_wins = rd_data_reg.task_priority > best_e_reg.task_priority;
            default:  cand_wins = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_ch.kind == KIND_DISP || in_ch.kind == KIND_REM)
                        state_next = (count_reg == '0) ? S_OUT : S_SCAN;
                    else
                        state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (found_next || (idx_reg + 1'b1 == count_reg))
                    state_next = found_next ? S_SHIFT_RD : S_OUT;
            end
            S_SHIFT_RD: state_next = (idx_next >= count_reg) ? S_OUT : S_SHIFT;
            S_SHIFT:    state_next = (idx_next >= count_reg) ? S_OUT : S_SHIFT;
            S_OUT:      state_next = out_ch.ready ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        best_e_next = best_e_reg;
        found_next  = found_reg;
        gv_next     = gv_reg;
        gid_next    = gid_reg;
        st_next     = st_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = in_e;
        unique case (state_reg)
            S_IDLE:
            begin
                gv_next    = 1'b0;
                gid_next   = '0;
                st_next    = ST_OK;
                idx_next   = '0;
                best_next  = '0;
                found_next = 1'b0;
                if (accept)
                begin
                    unique case (kind_t'(in_ch.kind))
                        KIND_ENQ:
                        begin
                            if (count_reg >= CW'(QUEUE_DEPTH))
                                st_next = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_DISP:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            rd_en = 1'b1;
                        end
                        KIND_REM:
                        begin
                            if (count_reg == '0)
                                st_next = ST_NOID;
                            rd_en = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds entry idx_reg.
                if (kind_reg == KIND_REM)
                begin
                    if (rd_data_reg.task_id == tid_reg)
                    begin
                        found_next = 1'b1;
                        best_next  = idx_reg;
                    end
                    else if (idx_reg + 1'b1 == count_reg)
                        st_next = ST_NOID;
                end
                else
                begin
                    if (idx_reg == '0 || cand_wins)
                    begin
                        best_next   = idx_reg;
                        best_e_next = rd_data_reg;
                    end
                    if (idx_reg + 1'b1 == count_reg)
                        found_next = 1'b1;
                end
                if (found_next)
                begin
                    if (kind_reg == KIND_DISP)
                    begin
                        gv_next  = 1'b1;
                        gid_next = (idx_reg == '0 || cand_wins) ? rd_data_reg.task_id
                                                                : best_e_reg.task_id;
                    end
                    idx_next = best_next + 1'b1;
                    rd_en    = (best_next + 1'b1 < count_reg);
                    rd_addr  = AW'(best_next + 1'b1);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_reg + 1'b1);
                end
            end
            S_SHIFT_RD, S_SHIFT:
            begin
                // Move entry idx-1+1 down: data read last cycle is entry idx_reg.
                if (state_reg == S_SHIFT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - 1'b1);
                    wr_data = rd_data_reg;
                end
                if (state_reg == S_SHIFT_RD)
                begin
                    idx_next = idx_reg;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                rd_en   = (idx_next < count_reg);
                rd_addr = AW'(idx_next);
                if (state_next == S_OUT)
                    count_next = count_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= 3'd0;
            count_reg      <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_pending_reg <= rd_en;
            if (policy_we)
                policy_reg <= policy_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        best_e_reg <= best_e_next;
        found_reg  <= found_next;
        gv_reg     <= gv_next;
        gid_reg    <= gid_next;
        st_reg     <= st_next;
        if (accept)
        begin
            kind_reg <= kind_t'(in_ch.kind);
            tid_reg  <= in_ch.task_id;
        end
    end

    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.grant_valid = gv_reg;
    assign out_ch.grant_id    = gid_reg;
    assign out_ch.status      = st_reg;
    assign out_ch.queue_count = CountWidth'(count_reg);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");
    a_grant_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.grant_valid |-> out_ch.grant_id == 8'd0)
        else $error("grant id without grant");
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> rd_pending_reg)
        else $error("scan without memory read");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
`endif

endmodule

// File: dv/multi_policy_ready_queue_scheduler_test.sv
`timescale 1ns / 100ps

module multi_policy_ready_queue_scheduler_test;
    import mprqs_pkg::*;

    localparam int Depth = 16;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic       grant_valid;
        logic [7:0] grant_id;
        logic [1:0] status;
        logic [4:0] queue_count;
    } grant_t;

    logic       clk;
    logic       rst_n;
    logic       policy_we;
    logic [2:0] policy_wdata;

    mprqs_in_if  in_ch ();
    mprqs_out_if out_ch ();

    multi_policy_ready_queue_scheduler #(.QUEUE_DEPTH(Depth)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy_we    (policy_we),
        .policy_wdata (policy_wdata),
        .in_ch        (in_ch.sink),
        .out_ch       (out_ch.source)
    );

    // Predictor state: its own copy of the ready queue and policy.
    entry_t     model_queue [$];
    logic [2:0] model_policy;
    grant_t     pending_grants [$];

    int errors;
    int items_sent;
    int grants_checked;
    int idle_cycles;
    int gap_left;
    int burst_left;
    bit burst_mode;
    int stall_phase;
    bit no_stall;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit candidate_wins(entry_t c, entry_t b, logic [2:0] pol);
        logic signed [17:0] c_rem;
        logic signed [17:0] b_rem;
        logic [31:0]        c_tgt;
        logic [31:0]        b_tgt;
        begin
            c_rem = $signed({2'b00, c.target_time}) - $signed({2'b00, c.served_time});
            b_rem = $signed({2'b00, b.target_time}) - $signed({2'b00, b.served_time});
            c_tgt = (c.target_time == 16'd0) ? 32'd1 : {16'd0, c.target_time};
            b_tgt = (b.target_time == 16'd0) ? 32'd1 : {16'd0, b.target_time};
            case (pol)
                POL_SJF:  return c.target_time < b.target_time;
                POL_SRTN: return c_rem < b_rem;
                POL_GUAR: return ({16'd0, c.served_time} * b_tgt)
                                 < ({16'd0, b.served_time} * c_tgt);
                POL_PRIO: return c.task_priority > b.task_priority;
                default:  return 1'b0;
            endcase
        end
    endfunction

    function automatic grant_t schedule_item(kind_t k, entry_t e);
        grant_t g;
        int     best;
        begin
            g = '0;
            case (k)
                KIND_ENQ:
                    if (model_queue.size() >= Depth)
                        g.status = ST_FULL;
                    else
                        model_queue.push_back(e);
                KIND_DISP:
                    if (model_queue.size() == 0)
                        g.status = ST_EMPTY;
                    else
                    begin
                        best = 0;
                        for (int i = 1; i < model_queue.size(); i++)
                            if (candidate_wins(model_queue[i], model_queue[best], model_policy))
                                best = i;
                        g.grant_valid = 1'b1;
                        g.grant_id = model_queue[best].task_id;
                        model_queue.delete(best);
                    end
                KIND_REM:
                begin
                    g.status = ST_NOID;
                    for (int i = 0; i < model_queue.size(); i++)
                        if (model_queue[i].task_id == e.task_id)
                        begin
                            model_queue.delete(i);
                            g.status = ST_OK;
                            break;
                        end
                end
                default: ;
            endcase
            g.queue_count = 5'(model_queue.size());
            return g;
        end
    endfunction

    task automatic send_item(kind_t k, logic [7:0] id, logic [15:0] tgt, logic [15:0] srv,
                             logic [15:0] pri);
        entry_t e;
        begin
            e = {id, tgt, srv, pri};
            // Bursts of random length separated by random gaps.
            if (burst_left == 0)
            begin
                burst_mode = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(1, 12);
                gap_left = burst_mode ? 0 : $urandom_range(0, 6);
            end
            burst_left--;
            if (gap_left > 0)
                in_ch.valid <= 1'b0;
            while (gap_left > 0)
            begin
                @(posedge clk);
                gap_left--;
            end
            in_ch.valid <= 1'b1;
            in_ch.kind <= k;
            in_ch.task_id <= id;
            in_ch.target_time <= tgt;
            in_ch.served_time <= srv;
            in_ch.task_priority <= pri;
            do
                @(posedge clk);
            while (!in_ch.ready);
            pending_grants.push_back(schedule_item(k, e));
            items_sent++;
        end
    endtask

    task automatic drain_grants();
        begin
            in_ch.valid <= 1'b0;
            while (pending_grants.size() != 0)
                @(posedge clk);
            repeat (2 * Depth + 10) @(posedge clk);
        end
    endtask

    task automatic write_policy(logic [2:0] p);
        begin
            drain_grants();
            policy_we <= 1'b1;
            policy_wdata <= p;
            @(posedge clk);
            policy_we <= 1'b0;
            model_policy = p;
        end
    endtask

    task automatic send_random_enq(bit narrow_ids);
        begin
            send_item(KIND_ENQ, narrow_ids ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_directed_extremes();
        begin
            send_item(KIND_DISP, 8'd0, 16'd1, 16'd0, 16'd0);
            send_item(KIND_REM, 8'd5, 16'd1, 16'd0, 16'd0);
            send_item(KIND_NOP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            send_item(KIND_ENQ, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
            send_item(KIND_ENQ, 8'h00, 16'd1, 16'd0, 16'h8000);
            send_item(KIND_ENQ, 8'h00, 16'd0, 16'd5, 16'hFFFF);
            send_item(KIND_REM, 8'h00, 16'd1, 16'd0, 16'd0);
            for (int i = 0; i < Depth; i++)
                send_item(KIND_ENQ, 8'(i), 16'(i * 4000 + 1), 16'(i * 300),
                          16'(i * 1000 - 8000));
            send_item(KIND_REM, 8'hAA, 16'd1, 16'd0, 16'd0);
            send_item(KIND_DISP, 8'd0, 16'd1, 16'd0, 16'd0);
        end
    endtask

    // Fill to a random level, then dispatch it dry under policy p.
    task automatic test_policy_drain(logic [2:0] p, int rounds);
        begin
            write_policy(p);
            for (int r = 0; r < rounds; r++)
            begin
                while (model_queue.size() < Depth - $urandom_range(0, 8))
                    send_random_enq(1'b1);
                if ($urandom_range(0, 1))
                    send_item(KIND_REM, 8'($urandom_range(0, 7)), 16'd1, 16'd0, 16'd0);
                while (model_queue.size() != 0)
                    send_item(KIND_DISP, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
            end
        end
    endtask

    task automatic test_random_mix(int count);
        int pick;
        begin
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    send_random_enq(1'($urandom_range(0, 1)));
                else if (pick < 15)
                    send_item(KIND_DISP, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else if (pick < 19)
                    send_item(KIND_REM, $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                              : 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else
                    send_item(KIND_NOP, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                if (n % 97 == 50)
                    write_policy(3'($urandom_range(0, 7)));
            end
        end
    endtask

    // Receiver stalls on a repeating pattern, now and then switched off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
            no_stall <= 1'b0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 23;
            if (stall_phase == 0)
                no_stall <= ($urandom_range(0, 2) == 0);
            out_ch.ready <= no_stall || !(stall_phase % 5 == 1 || stall_phase % 7 == 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            grant_t got;
            grant_t want;
            got = {out_ch.grant_valid, out_ch.grant_id, out_ch.status, out_ch.queue_count};
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_grants.pop_front();
                grants_checked++;
                if (got.grant_valid !== want.grant_valid)
                begin
                    $display("%0t: grant_valid expected %0d actual %0d", $time,
                             want.grant_valid, got.grant_valid);
                    errors++;
                end
                if (got.grant_id !== want.grant_id)
                begin
                    $display("%0t: grant_id expected %0d actual %0d", $time,
                             want.grant_id, got.grant_id);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.queue_count !== want.queue_count)
                begin
                    $display("%0t: queue_count expected %0d actual %0d", $time,
                             want.queue_count, got.queue_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("multi_policy_ready_queue_scheduler_test failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        grants_checked = 0;
        idle_cycles = 0;
        gap_left = 0;
        burst_left = 0;
        burst_mode = 0;
        model_policy = POL_RR;
        rst_n = 1'b0;
        policy_we = 1'b0;
        policy_wdata = 3'd0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_NOP;
        in_ch.task_id = 8'd0;
        in_ch.target_time = 16'd0;
        in_ch.served_time = 16'd0;
        in_ch.task_priority = 16'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_policy_drain(POL_SJF, 2);
        test_policy_drain(POL_SRTN, 2);
        test_policy_drain(POL_GUAR, 2);
        test_policy_drain(POL_PRIO, 2);
        test_policy_drain(3'd7, 1);
        test_policy_drain(POL_RR, 1);
        test_random_mix(330);
        drain_grants();

        $display("Sent %0d items and checked %0d results across all policies,", items_sent,
                 grants_checked);
        $display("including full, empty, missing id, ignored kind and out-of-range policy.");
        if (errors == 0 && pending_grants.size() == 0)
            $display("multi_policy_ready_queue_scheduler_test passed");
        else
            $display("multi_policy_ready_queue_scheduler_test failed");
        $finish;
    end
endmodule

// File: multi_policy_ready_queue_scheduler.f
hdl/mprqs_pkg.sv
hdl/mprqs_if.sv
hdl/multi_policy_ready_queue_scheduler.sv
dv/multi_policy_ready_queue_scheduler_test.sv
